[src/ebi_pkg.sv]
`default_nettype none
package ebi_pkg;

    // Widths of the item fields and of the register port
    localparam int KEY_W  = 8;
    localparam int HASH_W = 28;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    // Hash arithmetic
    localparam int STEP_SHIFT = 4;
    localparam int TOP_W      = 4;

    // Register map, indexed by paddr[2]
    localparam logic REG_TABLE_SIZE = 1'b0;
    localparam logic REG_FOLD_CASE  = 1'b1;

    // Register reset values
    localparam logic [DATA_W-1:0] TABLE_SIZE_RST = 32'd1;

    // ASCII letter range for case folding
    localparam logic [KEY_W-1:0] LOWER_A    = 8'h61;
    localparam logic [KEY_W-1:0] LOWER_Z    = 8'h7A;
    localparam logic [KEY_W-1:0] CASE_DELTA = 8'h20;

    // Default depth of the finished-hash queue
    localparam int QUEUE_DEPTH_DEF = 2;

    // One finished hash moving from front to back
    typedef struct packed {
        logic              valid;
        logic [HASH_W-1:0] hash;
    } ebi_entry_t;

    // Fold one byte into the running hash
    function automatic logic [HASH_W-1:0] fold_byte(
        input logic [HASH_W-1:0] h,
        input logic [KEY_W-1:0]  c
    );
        logic [DATA_W-1:0] sum;
        logic [HASH_W-1:0] mix;
        sum = {h, {STEP_SHIFT{1'b0}}} + {{(DATA_W-KEY_W){1'b0}}, c};
        mix = {{(HASH_W-TOP_W-STEP_SHIFT){1'b0}}, sum[DATA_W-1 -: TOP_W],
               {STEP_SHIFT{1'b0}}};
        return sum[HASH_W-1:0] ^ mix;
    endfunction

endpackage
`default_nettype wire

[src/ebi_front.sv]
`default_nettype none
module ebi_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [ebi_pkg::KEY_W-1:0] key_byte,
    input  logic                      byte_present,
    input  logic                      key_end,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      fold_case,
    input  logic                      push_ready,
    output ebi_pkg::ebi_entry_t       push
);
    import ebi_pkg::*;

    logic [HASH_W-1:0] running_hash_reg;
    logic [HASH_W-1:0] running_hash_next;
    logic [KEY_W-1:0]  byte_cased;
    logic [HASH_W-1:0] hash_upd;
    logic              accept;

    // Stall input only while the queue is full
    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;

    // Fold lower-case letters to upper case when enabled
    always_comb
    begin
        byte_cased = key_byte;
        if (fold_case && (key_byte >= LOWER_A) && (key_byte <= LOWER_Z))
        begin
            byte_cased = key_byte - CASE_DELTA;
        end
    end

    // Advance the hash by this item's byte, if any
    assign hash_upd = byte_present ? fold_byte(running_hash_reg, byte_cased)
                                   : running_hash_reg;

    // Hand the finished hash to the queue on the last item of a key
    assign push.valid = accept && key_end;
    assign push.hash  = hash_upd;

    always_comb
    begin
        running_hash_next = running_hash_reg;
        if (accept)
        begin
            running_hash_next = key_end ? '0 : hash_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_hash_reg <= '0;
        end
        else
        begin
            running_hash_reg <= running_hash_next;
        end
    end

endmodule
`default_nettype wire

[src/ebi_queue.sv]
`default_nettype none
module ebi_queue #(
    parameter int DEPTH = ebi_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ebi_pkg::ebi_entry_t push,
    output logic                push_ready,
    output ebi_pkg::ebi_entry_t head,
    input  logic                pop
);
    import ebi_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [HASH_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.hash  = mem[rd_ptr_reg];

    assign do_push = push.valid && push_ready;
    assign do_pop  = pop && head.valid;

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.hash;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

[src/ebi_back.sv]
`default_nettype none
module ebi_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ebi_pkg::ebi_entry_t        head,
    output logic                       pop,
    input  logic [ebi_pkg::DATA_W-1:0] table_size,
    output logic [ebi_pkg::DATA_W-1:0] bucket_index,
    output logic [ebi_pkg::HASH_W-1:0] raw_hash,
    output logic                       out_valid,
    input  logic                       out_ready
);
    import ebi_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;
    localparam int         STEP_W  = $clog2(HASH_W);

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] hash_next;
    logic [HASH_W-1:0] dvd_reg;
    logic [HASH_W-1:0] dvd_next;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] rem_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] bucket_reg;
    logic [DATA_W-1:0] bucket_next;
    logic [HASH_W-1:0] raw_reg;
    logic [HASH_W-1:0] raw_next;
    logic [DATA_W:0]   rem_shift;
    logic [DATA_W:0]   rem_diff;
    logic [DATA_W-1:0] rem_step;
    logic              out_free;

    assign out_valid    = out_valid_reg;
    assign bucket_index = bucket_reg;
    assign raw_hash     = raw_reg;
    assign out_free     = !out_valid_reg || out_ready;

    // Take a new hash only when the divider is free
    assign pop = (state_reg == ST_IDLE) && head.valid;

    // One restoring remainder step: bring down the next dividend bit
    assign rem_shift = {rem_reg, dvd_reg[HASH_W-1]};
    assign rem_diff  = rem_shift - {1'b0, table_size};
    assign rem_step  = rem_diff[DATA_W] ? rem_shift[DATA_W-1:0] : rem_diff[DATA_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        hash_next      = hash_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg;
        bucket_next    = bucket_reg;
        raw_next       = raw_reg;

        // Drop the result once it is taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    hash_next  = head.hash;
                    dvd_next   = head.hash;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next  = rem_step;
                dvd_next  = {dvd_reg[HASH_W-2:0], 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(HASH_W - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hold the result until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    bucket_next    = (table_size == '0) ? '0 : rem_reg;
                    raw_next       = hash_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        hash_reg   <= hash_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        step_reg   <= step_next;
        bucket_reg <= bucket_next;
        raw_reg    <= raw_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

[src/elf_hash_bucket_index_unit.sv]
// ELF/PJW 28-bit string hash with bucket selection.
//
// Input channel (in_valid/in_ready): one key byte per item with byte_present
// and key_end. Bytes fold into the running hash at one item per cycle while
// in_ready is high. An item with key_end closes the key and queues its hash;
// the running hash then restarts at zero. An empty key is a single item with
// byte_present low. Output channel (out_valid/out_ready): one item per key
// carrying raw_hash and bucket_index = raw_hash mod table_size (0 when
// table_size is 0). The modulo is a restoring remainder unit, one dividend
// bit per cycle; the back end takes no new key until the last one is done, so
// keys that arrive meanwhile queue in a QUEUE_DEPTH-entry hash queue, and
// in_ready drops only while it is full.
// Configuration (APB): table_size at 0x0, fold_case at 0x4; write only while
// no key is in flight. Reset clears the running hash, the queue and the
// output, sets table_size to 1 and fold_case to 0.
// When the receiver stalls, the result holds in the output register, the
// divider finishes and waits, the queue fills, and then input stalls.
`default_nettype none
module elf_hash_bucket_index_unit #(
    parameter int QUEUE_DEPTH = ebi_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [ebi_pkg::KEY_W-1:0]  key_byte,
    input  logic                       byte_present,
    input  logic                       key_end,
    input  logic                       in_valid,
    output logic                       in_ready,
    output logic [ebi_pkg::DATA_W-1:0] bucket_index,
    output logic [ebi_pkg::HASH_W-1:0] raw_hash,
    output logic                       out_valid,
    input  logic                       out_ready,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ebi_pkg::ADDR_W-1:0] paddr,
    input  logic [ebi_pkg::DATA_W-1:0] pwdata,
    output logic [ebi_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import ebi_pkg::*;

    logic [DATA_W-1:0] table_size_reg;
    logic [DATA_W-1:0] table_size_next;
    logic              fold_case_reg;
    logic              fold_case_next;
    logic              cfg_wr;
    ebi_entry_t        push;
    ebi_entry_t        head;
    logic              push_ready;
    logic              pop;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        table_size_next = table_size_reg;
        fold_case_next  = fold_case_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                REG_TABLE_SIZE: table_size_next = pwdata;
                REG_FOLD_CASE:  fold_case_next  = pwdata[0];
                default:        table_size_next = table_size_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_TABLE_SIZE: prdata = table_size_reg;
            REG_FOLD_CASE:  prdata = {{(DATA_W-1){1'b0}}, fold_case_reg};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= TABLE_SIZE_RST;
            fold_case_reg  <= 1'b0;
        end
        else
        begin
            table_size_reg <= table_size_next;
            fold_case_reg  <= fold_case_next;
        end
    end

    ebi_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_byte     (key_byte),
        .byte_present (byte_present),
        .key_end      (key_end),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .fold_case    (fold_case_reg),
        .push_ready   (push_ready),
        .push         (push)
    );

    ebi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .head       (head),
        .pop        (pop)
    );

    ebi_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .table_size   (table_size_reg),
        .bucket_index (bucket_index),
        .raw_hash     (raw_hash),
        .out_valid    (out_valid),
        .out_ready    (out_ready)
    );

endmodule
`default_nettype wire

[src/ebi_checker.sv]
`default_nettype none
module ebi_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [ebi_pkg::DATA_W-1:0] bucket_index,
    input  logic [ebi_pkg::HASH_W-1:0] raw_hash,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic                       psel,
    input  logic                       pwrite,
    input  logic [ebi_pkg::ADDR_W-1:0] paddr,
    input  logic [ebi_pkg::DATA_W-1:0] prdata,
    input  logic                       pready
);
    import ebi_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(raw_hash) && $stable(bucket_index))
        else $error("result changed while stalled");

    // A remainder never exceeds its dividend
    a_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> bucket_index <= {{(DATA_W-HASH_W){1'b0}}, raw_hash})
        else $error("bucket index above hash");

    // The fold_case register reads back as a single bit
    a_fold_read: assert property (@(posedge clk) disable iff (!rst_n)
        psel && !pwrite && (paddr[2] == REG_FOLD_CASE) |-> prdata[DATA_W-1:1] == '0)
        else $error("fold_case read has stray bits");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        psel |-> pready)
        else $error("register port not ready");

endmodule

bind elf_hash_bucket_index_unit ebi_checker u_ebi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .bucket_index (bucket_index),
    .raw_hash     (raw_hash),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .psel         (psel),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .prdata       (prdata),
    .pready       (pready)
);
`default_nettype wire

[dv/tb_top.sv]
module tb_top;
    import ebi_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 800;
    localparam int SEGMENTS      = 3;
    localparam int RUN_LIMIT     = 4_000_000;

    typedef enum logic [1:0] {ROW_ITEM, ROW_SET_SIZE, ROW_SET_FOLD} row_kind_t;

    typedef struct packed {
        logic [DATA_W-1:0] bucket;
        logic [HASH_W-1:0] hash;
    } hash_result_t;

    // Columns: kind, register value, key byte, present, last,
    //          typed result flag, bucket, hash
    typedef struct packed {
        row_kind_t         kind;
        logic [DATA_W-1:0] value;
        logic [KEY_W-1:0]  key_byte;
        logic              present;
        logic              last;
        logic              typed;
        logic [DATA_W-1:0] bucket;
        logic [HASH_W-1:0] hash;
    } key_row_t;

    localparam key_row_t DIRECTED_ROWS [29] = '{
        // reset settings: one bucket, no case folding
        '{ROW_ITEM,     32'h0, 8'h00, 1'b0, 1'b1, 1'b1, 32'h0, 28'h0},
        '{ROW_ITEM,     32'h0, 8'hFF, 1'b1, 1'b1, 1'b1, 32'h0, 28'hFF},
        '{ROW_ITEM,     32'h0, 8'h61, 1'b1, 1'b1, 1'b1, 32'h0, 28'h61},
        '{ROW_ITEM,     32'h0, 8'h5A, 1'b0, 1'b0, 1'b0, 32'h0, 28'h0},
        '{ROW_ITEM,     32'h0, 8'h00, 1'b1, 1'b1, 1'b1, 32'h0, 28'h0},
        // zero table size gives bucket zero
        '{ROW_SET_SIZE, 32'h0, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0, 28'h0},
        '{ROW_ITEM,     32'h0, 8'hFF, 1'b1, 1'b1, 1'b1, 32'h0, 28'hFF},
        // case folding: only a..z move
        '{ROW_SET_FOLD, 32'h1, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0, 28'h0},
        '{ROW_ITEM,     32'h0, 8'h61, 1'b1, 1'b1, 1'b1, 32'h0, 28'h41},
        '{ROW_ITEM,     32'h0, 8'h7A, 1'b1, 1'b1, 1'b1, 32'h0, 28'h5A},
        '{ROW_ITEM,     32'h0, 8'h7B, 1'b1, 1'b1, 1'b1, 32'h0, 28'h7B},
        '{ROW_ITEM,     32'h0, 8'h60, 1'b1, 1'b1, 1'b1, 32'h0, 28'h60},
        // largest table; long 0xFF key wraps the add and folds the top bits
        '{ROW_SET_SIZE, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0, 28'h0},
        '{ROW_ITEM,     32'h0, 8'hFF, 1'b1, 1'b0, 1'b0, 32'h0, 28'h0},
        '{ROW_ITEM,     32'h0, 8'hFF, 1'b1, 1'b0, 1'b0, 32'h0, 28'h0},
        '{ROW_ITEM,     32'h0, 8'hFF, 1'b1, 1'b0, 1'b0, 32'h0, 28'h0},
        '{ROW_ITEM,     32'h0, 8'hFF, 1'b1, 1'b0, 1'b0, 32'h0, 28'h0},
        '{ROW_ITEM,     32'h0, 8'hFF, 1'b1, 1'b0, 1'b0, 32'h0, 28'h0},
        '{ROW_ITEM,     32'h0, 8'hFF, 1'b1, 1'b0, 1'b0, 32'h0, 28'h0},
        '{ROW_ITEM,     32'h0, 8'hFF, 1'b1, 1'b0, 1'b0, 32'h0, 28'h0},
        '{ROW_ITEM,     32'h0, 8'hFF, 1'b1, 1'b1, 1'b0, 32'h0, 28'h0},
        // numeric key 0x12345678 in little-endian byte order
        '{ROW_SET_SIZE, 32'h7, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0, 28'h0},
        '{ROW_ITEM,     32'h0, 8'h78, 1'b1, 1'b0, 1'b0, 32'h0, 28'h0},
        '{ROW_ITEM,     32'h0, 8'h56, 1'b1, 1'b0, 1'b0, 32'h0, 28'h0},
        '{ROW_ITEM,     32'h0, 8'h34, 1'b1, 1'b0, 1'b0, 32'h0, 28'h0},
        '{ROW_ITEM,     32'h0, 8'h12, 1'b1, 1'b1, 1'b0, 32'h0, 28'h0},
        '{ROW_ITEM,     32'h0, 8'h00, 1'b0, 1'b1, 1'b1, 32'h0, 28'h0},
        // key closed by an item with no byte
        '{ROW_ITEM,     32'h0, 8'h41, 1'b1, 1'b0, 1'b0, 32'h0, 28'h0},
        '{ROW_ITEM,     32'h0, 8'h9C, 1'b0, 1'b1, 1'b0, 32'h0, 28'h0}
    };

    logic              clk;
    logic              rst_n        = 1'b0;
    logic [KEY_W-1:0]  key_byte     = '0;
    logic              byte_present = 1'b0;
    logic              key_end      = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_ready;
    logic [DATA_W-1:0] bucket_index;
    logic [HASH_W-1:0] raw_hash;
    logic              out_valid;
    logic              out_ready    = 1'b0;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [ADDR_W-1:0] paddr        = '0;
    logic [DATA_W-1:0] pwdata       = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Mirror of the block's registers and running hash
    logic [DATA_W-1:0] cfg_table_size = TABLE_SIZE_RST;
    logic              cfg_fold_case  = 1'b0;
    logic [HASH_W-1:0] key_hash       = '0;

    hash_result_t expected_hashes[$];
    int           fail_count     = 0;
    int           send_gap_pct   = 21;
    int           recv_stall_pct = 66;

    elf_hash_bucket_index_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_byte     (key_byte),
        .byte_present (byte_present),
        .key_end      (key_end),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .bucket_index (bucket_index),
        .raw_hash     (raw_hash),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        #RUN_LIMIT;
        $display("TEST FAILED");
        $finish;
    end

    // Fold one accepted item into the key hash; return 1 when it closes a key
    function automatic logic absorb_key_item(
        input  logic [KEY_W-1:0] b,
        input  logic             present,
        input  logic             last,
        output hash_result_t     res
    );
        logic [KEY_W-1:0]  ch;
        logic [DATA_W-1:0] sum;
        ch  = b;
        res = '0;
        if (present)
        begin
            if (cfg_fold_case && ch >= LOWER_A && ch <= LOWER_Z)
                ch = ch - CASE_DELTA;
            sum      = (DATA_W'(key_hash) << STEP_SHIFT) + DATA_W'(ch);
            key_hash = sum[HASH_W-1:0] ^ (HASH_W'(sum[DATA_W-1 -: TOP_W]) << STEP_SHIFT);
        end
        if (!last)
            return 1'b0;
        res.hash   = key_hash;
        res.bucket = (cfg_table_size == '0) ? '0 : DATA_W'(key_hash) % cfg_table_size;
        key_hash   = '0;
        return 1'b1;
    endfunction

    // Present one item after a random gap, hold it until accepted
    task automatic send_key_item(
        input logic [KEY_W-1:0] b,
        input logic             present,
        input logic             last,
        input logic             typed,
        input hash_result_t     typed_res
    );
        hash_result_t predicted;
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        key_byte     <= b;
        byte_present <= present;
        key_end      <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (absorb_key_item(b, present, last, predicted))
            expected_hashes.push_back(typed ? typed_res : predicted);
    endtask

    // Drop valid, wait out every pending result, then let the back end settle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_hashes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One APB write: setup, access, then idle
    task automatic write_config(input logic reg_sel, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_TABLE_SIZE)
            cfg_table_size = value;
        else
            cfg_fold_case = value[0];
        @(posedge clk);
    endtask

    // Random keys, mostly short, some long, some empty or with absent bytes
    task automatic send_random_keys(input int quota);
        int               counted;
        int               len;
        logic [KEY_W-1:0] b;
        logic             present;
        logic             last;
        counted = 0;
        while (counted < quota)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            if (len == 0)
            begin
                send_key_item(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
                counted++;
            end
            for (int i = 0; i < len; i++)
            begin
                case ($urandom_range(0, 2))
                    0:       b = 8'($urandom_range(LOWER_A, LOWER_Z));
                    1:       b = 8'($urandom_range(8'h40, 8'h7F));
                    default: b = 8'($urandom);
                endcase
                last    = (i == len - 1);
                present = last ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 9) != 0);
                send_key_item(b, present, last, 1'b0, '0);
                if (present || last)
                    counted++;
            end
        end
    endtask

    // Receiver stalls at random
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Check each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        hash_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_hashes.size() == 0)
            begin
                $error("unexpected result: bucket_index %0h raw_hash %0h",
                       bucket_index, raw_hash);
                fail_count++;
            end
            else
            begin
                want = expected_hashes.pop_front();
                if (bucket_index !== want.bucket)
                begin
                    $error("bucket_index: expected %0h, actual %0h", want.bucket, bucket_index);
                    fail_count++;
                end
                if (raw_hash !== want.hash)
                begin
                    $error("raw_hash: expected %0h, actual %0h", want.hash, raw_hash);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        logic [DATA_W-1:0] size;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (DIRECTED_ROWS[r])
        begin
            if (DIRECTED_ROWS[r].kind == ROW_ITEM)
            begin
                send_key_item(DIRECTED_ROWS[r].key_byte, DIRECTED_ROWS[r].present,
                              DIRECTED_ROWS[r].last, DIRECTED_ROWS[r].typed,
                              '{DIRECTED_ROWS[r].bucket, DIRECTED_ROWS[r].hash});
            end
            else
            begin
                drain_results();
                write_config(DIRECTED_ROWS[r].kind == ROW_SET_SIZE ? REG_TABLE_SIZE
                                                                   : REG_FOLD_CASE,
                             DIRECTED_ROWS[r].value);
            end
        end

        // Random keys under three idle mixes, new settings per segment
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_gap_pct   = 21;
                    recv_stall_pct = 66;
                end
                1:
                begin
                    send_gap_pct   = 66;
                    recv_stall_pct = 21;
                end
                default:
                begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int s = 0; s < SEGMENTS; s++)
            begin
                drain_results();
                case ($urandom_range(0, 5))
                    0:       size = '0;
                    1:       size = 32'd1;
                    2:       size = '1;
                    3:       size = $urandom_range(2, 16);
                    4:       size = $urandom_range(17, 5000);
                    default: size = $urandom;
                endcase
                write_config(REG_TABLE_SIZE, size);
                write_config(REG_FOLD_CASE, DATA_W'($urandom_range(0, 1)));
                send_random_keys(RANDOM_ITEMS / (3 * SEGMENTS));
            end
        end

        drain_results();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
src/ebi_pkg.sv
src/ebi_front.sv
src/ebi_queue.sv
src/ebi_back.sv
src/elf_hash_bucket_index_unit.sv
src/ebi_checker.sv
dv/tb_top.sv
